### design/rvsd_pkg.sv
// Shared types, codes and helpers for the rectangle video stream decoder.
// No dependencies; imported by rvsd_rect and rectangle_video_stream_decoder.
`default_nettype none

package rvsd_pkg;

    // Field widths
    localparam int unsigned ByteW  = 8;
    localparam int unsigned KindW  = 3;
    localparam int unsigned CoordW = 11;
    localparam int unsigned RateW  = 6;
    localparam int unsigned ScaleW = 3;
    localparam int unsigned PosW   = 3;
    localparam int unsigned CiW    = 2;

    // Stream data widths (fields packed, padded to whole bytes)
    localparam int unsigned OutFieldsW = 4 * CoordW + RateW + ScaleW;
    localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

    // Special byte values and limits
    localparam logic [ByteW-1:0]  EndFrame    = 8'hFF;
    localparam logic [ByteW-1:0]  EndVideo    = 8'hFE;
    localparam logic [ByteW-1:0]  MaxRate     = 8'd63;
    localparam logic [ByteW-1:0]  MaxScale    = 8'd6;
    localparam logic [ByteW-1:0]  Version     = 8'd1;
    localparam logic [ByteW-1:0]  OffsetReset = 8'd40;

    // Header byte positions
    localparam logic [PosW-1:0] PosRate    = 3'd5;
    localparam logic [PosW-1:0] PosVersion = 3'd6;
    localparam logic [PosW-1:0] PosScale   = 3'd7;

    // Index of the closing coordinate in a group of four
    localparam logic [CiW-1:0] CiLast = 2'd3;

    // Parse phase, one-hot
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_IGNORE = 4'b1000
    } t_phase;

    // Result kind codes
    typedef enum logic [KindW-1:0] {
        KIND_RECT      = 3'd0,
        KIND_FRAME_END = 3'd1,
        KIND_VIDEO_END = 3'd2,
        KIND_HDR_REJ   = 3'd3,
        KIND_HDR_ACC   = 3'd4
    } t_kind;

    // One result item
    typedef struct packed {
        t_kind              kind;
        logic [CoordW-1:0]  rect_x;
        logic [CoordW-1:0]  rect_y;
        logic [CoordW-1:0]  rect_width;
        logic [CoordW-1:0]  rect_height;
        logic [RateW-1:0]   frame_rate;
        logic [ScaleW-1:0]  scale;
    } t_result;

    // Rectangle geometry from the arithmetic unit
    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] w;
        logic [CoordW-1:0] h;
    } t_rect;

    // File identifier, header bytes 0 to 4
    function automatic logic [ByteW-1:0] ident_byte(input logic [PosW-1:0] pos);
        logic [ByteW-1:0] v;
        begin
            unique case (pos)
                3'd0:    v = 8'h38;
                3'd1:    v = 8'h34;
                3'd2:    v = 8'h56;
                3'd3:    v = 8'h49;
                3'd4:    v = 8'h44;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

    // Coordinate byte times scale factor; 255 * 7 fits in 11 bits
    function automatic logic [CoordW-1:0] scale_mul(input logic [ByteW-1:0]  b,
                                                    input logic [ScaleW-1:0] s);
        begin
            return CoordW'({3'd0, b} * {8'd0, s});
        end
    endfunction

endpackage

`default_nettype wire

### design/rvsd_rect.sv
// Rectangle arithmetic: scales the closing y, forms position and absolute size.
// Depends on rvsd_pkg.
`default_nettype none

module rvsd_rect
    import rvsd_pkg::*;
(
    input  wire logic [CoordW-1:0] i_x1s,     // first x, already scaled
    input  wire logic [CoordW-1:0] i_y1s,     // first y, already scaled
    input  wire logic [CoordW-1:0] i_x2s,     // second x, already scaled
    input  wire logic [ByteW-1:0]  i_y2,      // second y, raw byte
    input  wire logic [ScaleW-1:0] i_scale,
    input  wire logic [ByteW-1:0]  i_offset,
    output t_rect                  o_rect
);

    logic [CoordW-1:0] y2s;
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;

    // scale the last byte
    assign y2s = scale_mul(i_y2, i_scale);

    // absolute differences
    assign dx = (i_x2s >= i_x1s) ? (i_x2s - i_x1s) : (i_x1s - i_x2s);
    assign dy = (y2s   >= i_y1s) ? (y2s - i_y1s)   : (i_y1s - y2s);

    // zero size becomes one scaled pixel
    always_comb begin
        o_rect.x = i_x1s + {3'd0, i_offset};
        o_rect.y = i_y1s;
        o_rect.w = (dx == '0) ? {8'd0, i_scale} : dx;
        o_rect.h = (dy == '0) ? {8'd0, i_scale} : dy;
    end

endmodule

`default_nettype wire

### design/rectangle_video_stream_decoder.sv
// Top level of the rectangle video stream decoder: header parse, body parse,
// output register with skid stage. Depends on rvsd_pkg and rvsd_rect.
//
//  channel   | dir | handshake                     | payload
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: data_byte; tuser: file_start
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: rect fields, rate, scale;
//            |     |                               | tuser: kind
//  cfg       | in  | i_cfg_we                      | i_cfg_wdata: x_offset
//
// One byte per cycle while input ready is high. Parse state moves at the accept edge
// and any result is written to the output register (or the skid stage) at that same
// edge, so a result written to the output register is offered on the cycle after its
// byte. Input ready falls only while the skid stage holds an item, i.e. once a second
// result arrives while the first is still stalled in the output register.
// Reset is synchronous, active low; no clearing pass is needed.
`default_nettype none

module rectangle_video_stream_decoder
    import rvsd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config
    input  wire logic                 i_cfg_we,
    input  wire logic [ByteW-1:0]     i_cfg_wdata,
    // byte stream in
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [ByteW-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]           s_axis_tuser,   // [0] file_start
    // result stream out
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [10:0] rect_x, [21:11] rect_y, [32:22] rect_width, [43:33] rect_height,
    // [49:44] frame_rate, [52:50] scale, [55:53] zero
    output logic [OutDataW-1:0]       m_axis_tdata,
    output logic [KindW-1:0]          m_axis_tuser    // [2:0] kind
);

    // state
    t_phase             r_phase, n_phase;
    logic [PosW-1:0]    r_pos, n_pos;
    logic [ScaleW-1:0]  r_scale, n_scale;
    logic [RateW-1:0]   r_rate, n_rate;
    logic [CiW-1:0]     r_ci, n_ci;
    logic [ByteW-1:0]   r_offset;
    logic [CoordW-1:0]  r_held [3];

    // output stage
    logic               r_out_valid;
    t_result            r_out;
    logic               r_skid_valid;
    t_result            r_skid;

    logic               in_fire;
    logic               out_free;
    logic               new_valid;
    t_result            new_res;
    t_phase             cur_phase;
    logic [PosW-1:0]    cur_pos;
    logic [CiW-1:0]     cur_ci;
    logic [ByteW-1:0]   b;
    logic               hdr_ok;
    logic               held_we;
    t_rect              rect;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign b        = s_axis_tdata;

    // rectangle arithmetic
    rvsd_rect u_rect (
        .i_x1s    (r_held[0]),
        .i_y1s    (r_held[1]),
        .i_x2s    (r_held[2]),
        .i_y2     (b),
        .i_scale  (r_scale),
        .i_offset (r_offset),
        .o_rect   (rect)
    );

    // parse step for the byte on the input
    always_comb begin
        cur_phase = s_axis_tuser[0] ? PH_HEADER : r_phase;
        cur_pos   = s_axis_tuser[0] ? '0 : r_pos;
        cur_ci    = s_axis_tuser[0] ? '0 : r_ci;

        n_phase   = cur_phase;
        n_pos     = cur_pos;
        n_ci      = cur_ci;
        n_scale   = r_scale;
        n_rate    = r_rate;
        held_we   = 1'b0;
        new_valid = 1'b0;
        new_res   = '0;
        hdr_ok    = 1'b0;

        unique case (cur_phase)
            PH_HEADER: begin
                priority if (cur_pos < PosRate) begin
                    hdr_ok = (b == ident_byte(cur_pos));
                end else if (cur_pos == PosRate) begin
                    hdr_ok = (b != '0) && (b <= MaxRate);
                end else if (cur_pos == PosVersion) begin
                    hdr_ok = (b == Version);
                end else begin
                    hdr_ok = (b != '0) && (b <= MaxScale);
                end

                if (!hdr_ok) begin
                    n_phase      = PH_IGNORE;
                    new_valid    = 1'b1;
                    new_res.kind = KIND_HDR_REJ;
                end else if (cur_pos == PosScale) begin
                    n_phase            = PH_SKIP;
                    n_pos              = '0;
                    n_scale            = b[ScaleW-1:0];
                    new_valid          = 1'b1;
                    new_res.kind       = KIND_HDR_ACC;
                    new_res.frame_rate = r_rate;
                    new_res.scale      = b[ScaleW-1:0];
                end else begin
                    if (cur_pos == PosRate) begin
                        n_rate = b[RateW-1:0];
                    end
                    n_pos = cur_pos + 1'b1;
                end
            end
            PH_SKIP: begin
                n_phase = PH_BODY;
                n_ci    = '0;
            end
            PH_BODY: begin
                priority if (b == EndFrame) begin
                    n_ci         = '0;
                    new_valid    = 1'b1;
                    new_res.kind = KIND_FRAME_END;
                end else if (b == EndVideo) begin
                    n_ci         = '0;
                    n_phase      = PH_IGNORE;
                    new_valid    = 1'b1;
                    new_res.kind = KIND_VIDEO_END;
                end else if (cur_ci != CiLast) begin
                    held_we = 1'b1;
                    n_ci    = cur_ci + 1'b1;
                end else begin
                    n_ci                = '0;
                    new_valid           = 1'b1;
                    new_res.kind        = KIND_RECT;
                    new_res.rect_x      = rect.x;
                    new_res.rect_y      = rect.y;
                    new_res.rect_width  = rect.w;
                    new_res.rect_height = rect.h;
                end
            end
            PH_IGNORE: begin
                n_phase = PH_IGNORE;
            end
            default: begin
                n_phase = PH_IGNORE;
            end
        endcase
    end

    // parse state and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_ci     <= '0;
            r_scale  <= '0;
            r_rate   <= '0;
            r_offset <= OffsetReset;
        end else begin
            if (in_fire) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_ci    <= n_ci;
                r_scale <= n_scale;
                r_rate  <= n_rate;
            end
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
        end
    end

    // held coordinates, stored already scaled
    always_ff @(posedge i_clk) begin
        if (in_fire && held_we) begin
            r_held[cur_ci] <= scale_mul(b, r_scale);
        end
    end

    // output register plus skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= in_fire && new_valid;
                end else begin
                    r_out_valid  <= in_fire && new_valid;
                end
            end else if (in_fire && new_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                r_skid <= new_res;
            end else begin
                r_out <= new_res;
            end
        end else if (in_fire && new_valid) begin
            r_skid <= new_res;
        end
    end

    // ports
    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = OutDataW'({r_out.scale, r_out.frame_rate, r_out.rect_height,
                                      r_out.rect_width, r_out.rect_y, r_out.rect_x});

    // checks
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output register empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("skid item lost under output stall");

    a_ci_body_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ci != '0) |-> (r_phase == PH_BODY))
        else $error("coordinate count outside body phase");

    // a rejected header leaves its position behind while bytes are ignored
    a_pos_header_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> (r_phase == PH_HEADER || r_phase == PH_IGNORE))
        else $error("header position outside header parse");

    a_accept_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_HDR_ACC) |->
            (r_out.scale != '0 && r_out.frame_rate != '0))
        else $error("accepted header with zero rate or scale");

endmodule

`default_nettype wire
